@@ rtl/hsfd_pkg.sv @@
// Shared types, constants and functions of the humidity sensor frame decoder.
// Used by hsfd_frame, the top level and the port checker; depends on nothing.

package hsfd_pkg;

  // Frame layout: temp hi, temp lo, temp CRC, hum hi, hum lo, hum CRC
  localparam int unsigned FRAME_LEN = 6;

  localparam logic [2:0] POS_TEMP_HI = 3'd0;
  localparam logic [2:0] POS_TEMP_LO = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI = 3'd3;
  localparam logic [2:0] POS_HUM_LO = 3'd4;
  localparam logic [2:0] POS_HUM_CRC = 3'd5;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion scale and offset in hundredths
  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic signed [14:0] TEMP_OFFSET = -15'sd4500;
  localparam logic [16:0] FULL_SCALE = 17'd65535;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC = 2'd2
  } status_t;

  // Result of the byte now being processed
  typedef struct packed {
    logic last;
    logic signed [14:0] temperature;
    logic [13:0] humidity;
    status_t status;
    logic held_valid;
  } frame_res_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: x = q0*65536 + lo = q0*65535 + (lo + q0),
  // and lo + q0 stays below twice 65535, so one compare corrects the quotient
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] rem;
    q0 = x[30:16];
    rem = {1'b0, x[15:0]} + {2'b00, q0};
    return (rem >= FULL_SCALE) ? q0 + 15'd1 : q0;
  endfunction

endpackage

@@ rtl/hsfd_frame.sv @@
// Frame state of the decoder: byte position, CRC accumulation, raw words,
// scaled products and held readings. Depends on hsfd_pkg.

module hsfd_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output hsfd_pkg::frame_res_t res
);

  logic [2:0] byte_count;
  logic [2:0] byte_count_next;
  logic [7:0] crc_acc;
  logic [7:0] crc_acc_next;
  logic [15:0] raw_word;
  logic [15:0] raw_word_next;
  logic [30:0] temp_prod;
  logic [30:0] temp_prod_next;
  logic [29:0] hum_prod;
  logic [29:0] hum_prod_next;
  logic temp_crc_bad;
  logic temp_crc_bad_next;
  logic signed [14:0] held_temperature;
  logic [13:0] held_humidity;
  logic valid_flag;

  logic [2:0] pos;
  logic [7:0] crc_fold_out;
  logic frame_good;
  logic [14:0] temp_quot;
  logic [14:0] hum_quot;
  logic signed [14:0] temp_conv;
  logic [13:0] hum_conv;
  hsfd_pkg::status_t status_cur;

  // Position of this byte; a frame start restarts at the first byte
  assign pos = frame_start ? hsfd_pkg::POS_TEMP_HI : byte_count;

  // Advance CRC, raw word and scaled products by position
  always_comb begin
    crc_fold_out = hsfd_pkg::crc8_fold(
      ((pos == hsfd_pkg::POS_TEMP_HI) || (pos == hsfd_pkg::POS_HUM_HI)) ?
        hsfd_pkg::CRC_INIT : crc_acc, rx_byte);
    crc_acc_next = crc_acc;
    raw_word_next = raw_word;
    temp_prod_next = temp_prod;
    hum_prod_next = hum_prod;
    temp_crc_bad_next = temp_crc_bad;
    case (pos)
      hsfd_pkg::POS_TEMP_HI, hsfd_pkg::POS_HUM_HI: begin
        crc_acc_next = crc_fold_out;
        raw_word_next = {8'h00, rx_byte};
      end
      hsfd_pkg::POS_TEMP_LO: begin
        crc_acc_next = crc_fold_out;
        raw_word_next = {raw_word[7:0], rx_byte};
      end
      hsfd_pkg::POS_HUM_LO: begin
        crc_acc_next = crc_fold_out;
        raw_word_next = {raw_word[7:0], rx_byte};
        hum_prod_next = 30'(hsfd_pkg::HUM_SCALE) * 30'({raw_word[7:0], rx_byte});
      end
      hsfd_pkg::POS_TEMP_CRC: begin
        temp_crc_bad_next = (rx_byte != crc_acc);
        temp_prod_next = 31'(hsfd_pkg::TEMP_SCALE) * 31'(raw_word);
      end
      default: begin
      end
    endcase
    byte_count_next = (pos == hsfd_pkg::POS_HUM_CRC) ? hsfd_pkg::POS_TEMP_HI : pos + 3'd1;
  end

  // Humidity CRC and stored temperature CRC flag; convert stored products
  always_comb begin
    temp_quot = hsfd_pkg::div_full_scale(temp_prod);
    hum_quot = hsfd_pkg::div_full_scale({1'b0, hum_prod});
    temp_conv = hsfd_pkg::TEMP_OFFSET + $signed(temp_quot);
    hum_conv = hum_quot[13:0];
    if (temp_crc_bad) begin
      status_cur = hsfd_pkg::STATUS_TEMP_CRC;
    end else if (rx_byte != crc_acc) begin
      status_cur = hsfd_pkg::STATUS_HUM_CRC;
    end else begin
      status_cur = hsfd_pkg::STATUS_OK;
    end
    frame_good = (status_cur == hsfd_pkg::STATUS_OK);
    res.last = (pos == hsfd_pkg::POS_HUM_CRC);
    res.status = status_cur;
    res.temperature = frame_good ? temp_conv : held_temperature;
    res.humidity = frame_good ? hum_conv : held_humidity;
    res.held_valid = frame_good | valid_flag;
  end

  // Update state on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= hsfd_pkg::POS_TEMP_HI;
      crc_acc <= hsfd_pkg::CRC_INIT;
      raw_word <= '0;
      temp_prod <= '0;
      hum_prod <= '0;
      temp_crc_bad <= 1'b0;
      held_temperature <= '0;
      held_humidity <= '0;
      valid_flag <= 1'b0;
    end else if (step) begin
      byte_count <= byte_count_next;
      crc_acc <= crc_acc_next;
      raw_word <= raw_word_next;
      temp_prod <= temp_prod_next;
      hum_prod <= hum_prod_next;
      temp_crc_bad <= temp_crc_bad_next;
      if (res.last && frame_good) begin
        held_temperature <= temp_conv;
        held_humidity <= hum_conv;
        valid_flag <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/humidity_sensor_frame_decoder.sv @@
// Top level of the humidity sensor frame decoder: input register, frame
// state (hsfd_frame) and result register. Depends on hsfd_pkg, hsfd_frame.
//
// Usage: sensor bytes enter on the byte channel (byte_valid, byte_stall,
// rx_byte, frame_start) in frame order: temperature high, low, CRC, humidity
// high, low, CRC. frame_start marks the first byte of a frame and drops any
// partial frame. One result leaves on the result channel (result_valid,
// result_stall) for each sixth byte: held temperature and humidity in
// hundredths, status (ok, temperature CRC bad, humidity CRC bad) and
// held_valid. A failed frame keeps the earlier held readings.
// A result is valid once its last byte has passed the input register
// (where it waits while the result slot is full) and the result register
// has loaded. Throughput: one byte per cycle while byte_stall is low;
// the frame state updates in a single step out of the input register and
// both multiplies sit on register-to-register paths.
// Reset clears the byte position, CRC and held readings and empties both
// registers. When the receiver stalls, the result holds; bytes keep flowing
// until a second result is ready, then byte_stall rises.

module humidity_sensor_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [1:0]         status,
  output logic               held_valid
);

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_start;
  logic s1_go;
  logic out_free;
  hsfd_pkg::frame_res_t res;
  hsfd_pkg::status_t status_q;

  hsfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_go),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .res         (res)
  );

  // Move a byte on unless it finishes a frame and the result slot is full
  assign out_free = !result_valid || !result_stall;
  assign s1_go = s1_valid && (!res.last || out_free);
  assign byte_stall = s1_valid && !s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= rx_byte;
      s1_start <= frame_start;
    end
  end

  // Result register: load on a finished frame, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && res.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.last) begin
      temperature_centi <= res.temperature;
      humidity_centi <= res.humidity;
      status_q <= res.status;
      held_valid <= res.held_valid;
    end
  end

  assign status = status_q;

endmodule

@@ rtl/hsfd_port_check.sv @@
// Port checker for the humidity sensor frame decoder, with its bind to the
// top level. Depends on hsfd_pkg.

module hsfd_port_check (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [14:0] temperature_centi,
  input logic [13:0]        humidity_centi,
  input logic [1:0]         status
  ,input logic              held_valid
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temperature_centi)
      && $stable(humidity_centi) && $stable(status) && $stable(held_valid))
    else $error("stalled result changed");

  // An ok frame always leaves valid held readings
  a_ok_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == hsfd_pkg::STATUS_OK) |-> held_valid)
    else $error("ok status without held readings");

  // Before any good frame the readings stay at zero
  a_zero_before_good: assert property (@(posedge clk) disable iff (rst)
    result_valid && !held_valid |-> (temperature_centi == 15'sd0) && (humidity_centi == 14'd0))
    else $error("readings set without a good frame");

  // Humidity in range and status a known code
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (humidity_centi <= 14'd10000) && ((status == hsfd_pkg::STATUS_OK)
      || (status == hsfd_pkg::STATUS_TEMP_CRC) || (status == hsfd_pkg::STATUS_HUM_CRC)))
    else $error("result out of range");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind humidity_sensor_frame_decoder hsfd_port_check u_hsfd_port_check (
  .clk               (clk),
  .rst               (rst),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .temperature_centi (temperature_centi),
  .humidity_centi    (humidity_centi),
  .status            (status),
  .held_valid        (held_valid)
);
